/* src/md5_hash_engine_top_defines.svh */
// assertion macros used by the md5 controller
`ifndef MD5_HASH_ENGINE_TOP_DEFINES_SVH
`define MD5_HASH_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MD5_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5 same-cycle check failed");

// next-cycle implication, checked out of reset
`define MD5_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5 next-cycle check failed");

`endif

/* src/md5_pkg.sv */
// types, constants and round tables of the md5 hash engine
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BYTE_IN,
        BYTE_PAD80,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       push;
        logic       add_bits;
        logic       load_work;
        logic       do_round;
        logic       add_chain;
        logic       reset_msg;
        byte_sel_t  byte_sel;
        logic [5:0] round;
        logic [1:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_hi;
    } status_t;

    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [1:0] LAST_IDX = 2'd3;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] amt;
        case ({r[5:4], r[1:0]})
            4'h0: amt = 5'd7;
            4'h1: amt = 5'd12;
            4'h2: amt = 5'd17;
            4'h3: amt = 5'd22;
            4'h4: amt = 5'd5;
            4'h5: amt = 5'd9;
            4'h6: amt = 5'd14;
            4'h7: amt = 5'd20;
            4'h8: amt = 5'd4;
            4'h9: amt = 5'd11;
            4'ha: amt = 5'd16;
            4'hb: amt = 5'd23;
            4'hc: amt = 5'd6;
            4'hd: amt = 5'd10;
            4'he: amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

/* src/md5_in_if.sv */
// message byte channel
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (
        output valid, data_byte, byte_present, end_of_message,
        input  ready
    );

    modport sink (
        input  valid, data_byte, byte_present, end_of_message,
        output ready
    );
endinterface

/* src/md5_out_if.sv */
// digest word channel
interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (
        output valid, digest_word, word_index, last_word,
        input  ready
    );

    modport sink (
        input  valid, digest_word, word_index, last_word,
        output ready
    );
endinterface

/* src/md5_ctrl.sv */
// md5 controller: byte intake, padding, round sequencing and digest output
`include "md5_hash_engine_top_defines.svh"

module md5_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             byte_present,
    input  logic             end_of_message,
    input  logic             out_ready,
    input  md5_pkg::status_t status,
    output logic             in_ready,
    output logic             out_valid,
    output md5_pkg::cmd_t    cmd
);

    md5_pkg::state_t state_reg, state_next;
    logic [5:0]      round_reg, round_next;
    logic [1:0]      idx_reg, idx_next;
    logic            final_reg, final_next;
    logic            pad_started_reg, pad_started_next;
    logic            extra_reg, extra_next;
    logic            accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= md5_pkg::ST_IDLE;
            round_reg       <= '0;
            idx_reg         <= '0;
            final_reg       <= 1'b0;
            pad_started_reg <= 1'b0;
            extra_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            round_reg       <= round_next;
            idx_reg         <= idx_next;
            final_reg       <= final_next;
            pad_started_reg <= pad_started_next;
            extra_reg       <= extra_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        round_next       = '0;
        idx_next         = idx_reg;
        final_next       = final_reg;
        pad_started_next = pad_started_reg;
        extra_next       = extra_reg;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    final_next = end_of_message;
                    if (byte_present && status.fill_full)
                    begin
                        state_next = md5_pkg::ST_COMP;
                    end
                    else if (end_of_message)
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_PAD:
            begin
                if (!pad_started_reg)
                begin
                    pad_started_next = 1'b1;
                    // length lands in the next block when the marker is past 55
                    extra_next       = status.fill_hi;
                end
                if (status.fill_full)
                begin
                    state_next = md5_pkg::ST_COMP;
                end
            end
            md5_pkg::ST_COMP:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == md5_pkg::LAST_ROUND)
                begin
                    state_next = md5_pkg::ST_ADD;
                end
            end
            md5_pkg::ST_ADD:
            begin
                extra_next = 1'b0;
                if (final_reg && pad_started_reg && !extra_reg)
                begin
                    state_next = md5_pkg::ST_OUT;
                end
                else if (final_reg)
                begin
                    state_next = md5_pkg::ST_PAD;
                end
                else
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            md5_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == md5_pkg::LAST_IDX)
                    begin
                        state_next       = md5_pkg::ST_IDLE;
                        final_next       = 1'b0;
                        pad_started_next = 1'b0;
                        extra_next       = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = md5_pkg::BYTE_IN;
        cmd.round     = round_reg;
        cmd.out_idx   = idx_reg;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && byte_present)
                begin
                    cmd.push      = 1'b1;
                    cmd.add_bits  = 1'b1;
                    cmd.load_work = status.fill_full;
                end
            end
            md5_pkg::ST_PAD:
            begin
                cmd.push      = 1'b1;
                cmd.load_work = status.fill_full;
                if (!pad_started_reg)
                begin
                    cmd.byte_sel = md5_pkg::BYTE_PAD80;
                end
                else if (status.fill_hi && !extra_reg)
                begin
                    cmd.byte_sel = md5_pkg::BYTE_LEN;
                end
                else
                begin
                    cmd.byte_sel = md5_pkg::BYTE_ZERO;
                end
            end
            md5_pkg::ST_COMP:
            begin
                cmd.do_round = 1'b1;
            end
            md5_pkg::ST_ADD:
            begin
                cmd.add_chain = 1'b1;
            end
            md5_pkg::ST_OUT:
            begin
                out_valid     = 1'b1;
                cmd.reset_msg = out_ready && (idx_reg == md5_pkg::LAST_IDX);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `MD5_ASSERT_IMPL(a_ready_excl_valid, clk, rst_n, in_ready, !out_valid)
    `MD5_ASSERT_NEXT(a_last_round_adds, clk, rst_n, (state_reg == md5_pkg::ST_COMP) && (round_reg == md5_pkg::LAST_ROUND), state_reg == md5_pkg::ST_ADD)
    `MD5_ASSERT_NEXT(a_comp_starts_at_zero, clk, rst_n, (state_reg != md5_pkg::ST_COMP) && (state_next == md5_pkg::ST_COMP), round_reg == 6'd0)
    `MD5_ASSERT_NEXT(a_digest_done_idle, clk, rst_n, out_valid && out_ready && (idx_reg == md5_pkg::LAST_IDX), (state_reg == md5_pkg::ST_IDLE) && (idx_reg == 2'd0))

endmodule

/* src/md5_dp.sv */
// md5 datapath: block buffer, length counter, round unit and chaining words
module md5_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  md5_pkg::cmd_t    cmd,
    input  logic [7:0]       data_byte,
    output md5_pkg::status_t status,
    output logic [31:0]      digest_word,
    output logic [1:0]       word_index,
    output logic             last_word
);

    logic [31:0] chain_reg [4];
    logic [31:0] block_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;

    logic [7:0]  byte_val;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [3:0]  r_lo;
    logic [31:0] sum_val;
    logic [4:0]  amt;
    logic [31:0] rot_val;
    logic [31:0] b_new;

    assign status.fill_full = (fill_reg == 6'd63);
    assign status.fill_hi   = (fill_reg[5:3] == 3'b111);

    assign digest_word = chain_reg[cmd.out_idx];
    assign word_index  = cmd.out_idx;
    assign last_word   = (cmd.out_idx == md5_pkg::LAST_IDX);

    always_comb
    begin
        case (cmd.byte_sel)
            md5_pkg::BYTE_IN:    byte_val = data_byte;
            md5_pkg::BYTE_PAD80: byte_val = md5_pkg::PAD_BYTE;
            md5_pkg::BYTE_LEN:   byte_val = bits_reg[{fill_reg[2:0], 3'b000} +: 8];
            default:             byte_val = 8'h00;
        endcase
    end

    assign r_lo = cmd.round[3:0];

    always_comb
    begin
        case (cmd.round[5:4])
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = r_lo;
            end
            2'd1:
            begin
                f_val = (d_reg & b_reg) | (~d_reg & c_reg);
                g_idx = {r_lo[1:0], 2'b00} + r_lo + 4'd1;
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = {r_lo[2:0], 1'b0} + r_lo + 4'd5;
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = {r_lo[0], 3'b000} - r_lo;
            end
        endcase
    end

    assign sum_val = a_reg + f_val + md5_pkg::round_const(cmd.round) + block_reg[g_idx];
    assign amt     = md5_pkg::rot_amt(cmd.round);
    assign rot_val = (sum_val << amt) | (sum_val >> (6'd32 - {1'b0, amt}));
    assign b_new   = b_reg + rot_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                chain_reg[i] <= md5_pkg::CHAIN_INIT[i];
            end
            fill_reg <= '0;
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.reset_msg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_reg[i] <= md5_pkg::CHAIN_INIT[i];
                end
                fill_reg <= '0;
                bits_reg <= '0;
            end
            else
            begin
                if (cmd.push)
                begin
                    fill_reg <= fill_reg + 6'd1;
                end
                if (cmd.add_bits)
                begin
                    bits_reg <= bits_reg + 64'd8;
                end
                if (cmd.add_chain)
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                end
            end
        end
    end

    // every byte of a block is written before the block is compressed
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            block_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= byte_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (cmd.do_round)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

endmodule

/* src/md5_hash_engine_top.sv */
// md5 hash engine: one message byte per transaction, four digest words per message
// a byte is taken only while the engine is idle; a byte that fills a block starts a compression
// (64 rounds of the single round unit plus 1 chaining add)
// an end transaction pads at one byte per cycle, runs one or two
// compressions, then offers the four digest words one per cycle while ready is high
// async reset loads the initial chaining words, clears length and fill count
module md5_hash_engine_top (
    input  logic      clk,
    input  logic      rst_n,
    md5_in_if.sink    msg,
    md5_out_if.source digest
);

    md5_pkg::cmd_t    cmd;
    md5_pkg::status_t status;

    md5_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (msg.valid),
        .byte_present   (msg.byte_present),
        .end_of_message (msg.end_of_message),
        .out_ready      (digest.ready),
        .status         (status),
        .in_ready       (msg.ready),
        .out_valid      (digest.valid),
        .cmd            (cmd)
    );

    md5_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (msg.data_byte),
        .status      (status),
        .digest_word (digest.digest_word),
        .word_index  (digest.word_index),
        .last_word   (digest.last_word)
    );

endmodule
